[design/fxlv_pkg.sv]
package fxlv_pkg;

  // fixed point format of all external values
  localparam int FracBits = 24;

  // internal format of the hyperbolic functions
  localparam int HypBits = 30;
  localparam int TaylorTerms = 16;
  localparam logic [30:0] Ln2Q30 = 31'd744261118;
  localparam int SmileCutoff = 100;

  // register indexes
  localparam logic RegInitLogSpot = 1'b0;
  localparam logic RegInitVol = 1'b1;

  // input kinds
  localparam logic CmdStart = 1'b0;
  localparam logic CmdStep = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_INNER_MUL,
    ST_DRIFT_MUL,
    ST_INNER_SAT,
    ST_QUOT_MUL,
    ST_QUOT_UPD,
    ST_DEV_MUL,
    ST_DEV_CHK,
    ST_K_DIV,
    ST_K_END,
    ST_TAY_MUL,
    ST_TAY_RCP,
    ST_TAY_ACC,
    ST_EXP_SHIFT,
    ST_EXP_SQ,
    ST_TANH_SET,
    ST_TANH_DIV,
    ST_TANH_END,
    ST_SECH_DIV,
    ST_SECH_END,
    ST_SKEW_ACC,
    ST_SMILE_SUM,
    ST_VOL_MUL,
    ST_VOL_END,
    ST_DONE
  } state_e;

  // v / 2^s rounded half away from zero
  function automatic logic signed [71:0] rshr(input logic signed [71:0] v,
                                              input int unsigned s);
    logic [71:0] m;
    logic [71:0] half;
    half = 72'd1 << (s - 1);
    m = v[71] ? 72'(-v) : 72'(v);
    m = (m + half) >> s;
    rshr = v[71] ? -$signed(m) : $signed(m);
  endfunction

  // saturate to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [71:0] hi;
    logic signed [71:0] lo;
    hi = 72'sh7FFFFFFF;
    lo = {{40{1'b1}}, 32'h80000000};
    if (v > hi) sat32 = 32'sh7FFFFFFF;
    else if (v < lo) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

  // ceil(2^34 / n), exact truncating quotient for 30 bit dividends
  function automatic logic [34:0] recip(input logic [4:0] n);
    unique case (n)
      5'd1:  recip = 35'd17179869184;
      5'd2:  recip = 35'd8589934592;
      5'd3:  recip = 35'd5726623062;
      5'd4:  recip = 35'd4294967296;
      5'd5:  recip = 35'd3435973837;
      5'd6:  recip = 35'd2863311531;
      5'd7:  recip = 35'd2454267027;
      5'd8:  recip = 35'd2147483648;
      5'd9:  recip = 35'd1908874354;
      5'd10: recip = 35'd1717986919;
      5'd11: recip = 35'd1561806290;
      5'd12: recip = 35'd1431655766;
      5'd13: recip = 35'd1321528399;
      5'd14: recip = 35'd1227133514;
      5'd15: recip = 35'd1145324613;
      5'd16: recip = 35'd1073741824;
      default: recip = 35'd17179869184;
    endcase
  endfunction

endpackage

[design/fx_local_vol_path_step_unit.sv]
// channel        | dir | handshake                    | contents (lowest bit up)
// s_axis         | in  | s_axis_tvalid/s_axis_tready  | tdata: 10 fields, tuser cmd, tlast last date
// m_axis         | out | m_axis_tvalid/m_axis_tready  | tdata: log_spot_fx, next_volatility
// cfg            | in  | cfg_we_i                     | cfg_idx_i selects register, cfg_data_i
//
// a start transaction does no work, a step on the last date stops after the log quotient
// update, a step past the smile cutoff skips tanh and sech, and a full step skips the
// taylor series when exp(-|w|) underflows to zero: one shared 36x36 multiplier and one
// shared radix-2 divider do the work (ln2 range reduction, 16 two-multiply taylor terms,
// two divisions for tanh and sech). one transaction at a time; the result waits in an
// output register. rst_ni clears the registers, path state and control asynchronously.
module fx_local_vol_path_step_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // normal_sample, year_fraction, sqrt_year_fraction, next_spot_vol, skew_coef,
  // smile_coef, shape_coef, dom_log_money, for_log_money, log_forward_fx, zero pad
  input  logic [319:0] s_axis_tdata,
  // cmd
  input  logic         s_axis_tuser,
  // is_last_date
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // log_spot_fx, next_volatility
  output logic [63:0]  m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);

  localparam int F = fxlv_pkg::FracBits;
  localparam int H = fxlv_pkg::HypBits;
  localparam int ShL = (F <= H) ? H - F : 0;
  localparam int ShR = (F > H) ? F - H : 0;
  localparam logic signed [71:0] One = 72'sd1 << F;
  localparam logic [71:0] Cutoff = 72'(fxlv_pkg::SmileCutoff) << F;
  localparam logic [30:0] HypOne = 31'd1 << H;

  fxlv_pkg::state_e state_q, state_d;

  // configuration and path state
  logic signed [31:0] init_ls_q;
  logic [30:0]        init_vol_q;
  logic signed [31:0] lq_q;
  logic signed [31:0] cur_vol_q;

  // captured transaction
  logic signed [31:0] z_q, a_q, b_q, c_q, dom_q, frn_q, fwd_q;
  logic [30:0]        dt_q, sdt_q, svol_q;
  logic               last_q;

  // working registers
  logic signed [71:0] prod_q;
  logic signed [71:0] hold_q;
  logic signed [31:0] spot_q, vol_q, f_q;
  logic               neg_q;
  logic [7:0]         k_q;
  logic [29:0]        r_q;
  logic [30:0]        term_q, sum_q, u_q, th_q;
  logic [4:0]         n_q;

  // shared divider
  logic [32:0] rem_q;
  logic [30:0] low_q, quo_q;
  logic [31:0] dsr_q;
  logic [4:0]  cnt_q;

  // output register
  logic        out_valid_q;
  logic [31:0] out_spot_q, out_vol_q;

  logic               accept;
  logic               load_out;
  logic signed [35:0] mul_a, mul_b;
  logic signed [71:0] prod_d;

  logic signed [31:0] lq_new, spot_new, x_val, vol_new, f_new, f_cut;
  logic signed [71:0] w_val;
  logic [71:0]        wm_val, a_full;
  logic               cut_hit;
  logic [32:0]        div_sh;
  logic               div_ge;
  logic [30:0]        t_val, tay_term;
  logic [61:0]        numer_t, numer_s;
  logic signed [31:0] ths_val;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == fxlv_pkg::ST_IDLE);
  assign load_out = (state_q == fxlv_pkg::ST_DONE) && (!out_valid_q || m_axis_tready);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = {out_vol_q, out_spot_q};

  // combinational datapath pieces
  always_comb begin
    lq_new   = fxlv_pkg::sat32(72'(lq_q) + fxlv_pkg::rshr(prod_q, F));
    spot_new = fxlv_pkg::sat32(72'(lq_new) + 72'(dom_q) - 72'(frn_q));
    x_val    = fxlv_pkg::sat32(72'(spot_q) - 72'(fwd_q));
    w_val    = fxlv_pkg::rshr(prod_q, F);
    wm_val   = w_val[71] ? 72'(-w_val) : 72'(w_val);
    cut_hit  = (wm_val >= Cutoff);
    a_full   = (wm_val << ShL) >> ShR;
    f_cut    = w_val[71] ? fxlv_pkg::sat32(One - 72'(a_q) + 72'(b_q))
                         : fxlv_pkg::sat32(One + 72'(a_q) + 72'(b_q));
    tay_term = prod_q[64:34];
    t_val    = prod_q[60:30];
    numer_t  = 62'(HypOne - t_val) << H;
    numer_s  = 62'(u_q) << (H + 1);
    ths_val  = neg_q ? -$signed({1'b0, th_q}) : $signed({1'b0, th_q});
    f_new    = fxlv_pkg::sat32(One + hold_q + fxlv_pkg::rshr(prod_q, H));
    vol_new  = fxlv_pkg::sat32(fxlv_pkg::rshr(prod_q, F));
    div_sh   = {rem_q[31:0], low_q[30]};
    div_ge   = (div_sh >= {1'b0, dsr_q});
  end

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      fxlv_pkg::ST_INNER_MUL: begin
        mul_a = $signed({5'b0, sdt_q});
        mul_b = 36'(z_q);
      end
      fxlv_pkg::ST_DRIFT_MUL: begin
        mul_a = 36'(cur_vol_q);
        mul_b = $signed({5'b0, dt_q});
      end
      fxlv_pkg::ST_QUOT_MUL: begin
        mul_a = 36'(cur_vol_q);
        mul_b = 36'($signed(hold_q[31:0]));
      end
      fxlv_pkg::ST_DEV_MUL: begin
        mul_a = 36'(c_q);
        mul_b = 36'(x_val);
      end
      fxlv_pkg::ST_TAY_MUL: begin
        mul_a = $signed({5'b0, term_q});
        mul_b = $signed({6'b0, r_q});
      end
      fxlv_pkg::ST_TAY_RCP: begin
        mul_a = $signed({6'b0, prod_q[59:30]});
        mul_b = $signed({1'b0, fxlv_pkg::recip(n_q)});
      end
      fxlv_pkg::ST_EXP_SQ: begin
        mul_a = $signed({5'b0, u_q});
        mul_b = $signed({5'b0, u_q});
      end
      fxlv_pkg::ST_SECH_END: begin
        mul_a = 36'(a_q);
        mul_b = 36'(ths_val);
      end
      fxlv_pkg::ST_SKEW_ACC: begin
        mul_a = 36'(b_q);
        mul_b = $signed({5'b0, HypOne - quo_q});
      end
      fxlv_pkg::ST_VOL_MUL: begin
        mul_a = $signed({5'b0, svol_q});
        mul_b = 36'(f_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fxlv_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (s_axis_tuser == fxlv_pkg::CmdStart) ? fxlv_pkg::ST_DONE
                                                          : fxlv_pkg::ST_INNER_MUL;
        end
      end
      fxlv_pkg::ST_INNER_MUL: state_d = fxlv_pkg::ST_DRIFT_MUL;
      fxlv_pkg::ST_DRIFT_MUL: state_d = fxlv_pkg::ST_INNER_SAT;
      fxlv_pkg::ST_INNER_SAT: state_d = fxlv_pkg::ST_QUOT_MUL;
      fxlv_pkg::ST_QUOT_MUL:  state_d = fxlv_pkg::ST_QUOT_UPD;
      fxlv_pkg::ST_QUOT_UPD:  state_d = last_q ? fxlv_pkg::ST_DONE : fxlv_pkg::ST_DEV_MUL;
      fxlv_pkg::ST_DEV_MUL:   state_d = fxlv_pkg::ST_DEV_CHK;
      fxlv_pkg::ST_DEV_CHK:   state_d = cut_hit ? fxlv_pkg::ST_VOL_MUL : fxlv_pkg::ST_K_DIV;
      fxlv_pkg::ST_K_DIV: begin
        if (cnt_q == 5'd1) state_d = fxlv_pkg::ST_K_END;
      end
      fxlv_pkg::ST_K_END: begin
        state_d = (quo_q[7:0] >= 8'd31) ? fxlv_pkg::ST_EXP_SQ : fxlv_pkg::ST_TAY_MUL;
      end
      fxlv_pkg::ST_TAY_MUL:   state_d = fxlv_pkg::ST_TAY_RCP;
      fxlv_pkg::ST_TAY_RCP:   state_d = fxlv_pkg::ST_TAY_ACC;
      fxlv_pkg::ST_TAY_ACC: begin
        state_d = (n_q == 5'(fxlv_pkg::TaylorTerms)) ? fxlv_pkg::ST_EXP_SHIFT
                                                     : fxlv_pkg::ST_TAY_MUL;
      end
      fxlv_pkg::ST_EXP_SHIFT: state_d = fxlv_pkg::ST_EXP_SQ;
      fxlv_pkg::ST_EXP_SQ:    state_d = fxlv_pkg::ST_TANH_SET;
      fxlv_pkg::ST_TANH_SET:  state_d = fxlv_pkg::ST_TANH_DIV;
      fxlv_pkg::ST_TANH_DIV: begin
        if (cnt_q == 5'd1) state_d = fxlv_pkg::ST_TANH_END;
      end
      fxlv_pkg::ST_TANH_END:  state_d = fxlv_pkg::ST_SECH_DIV;
      fxlv_pkg::ST_SECH_DIV: begin
        if (cnt_q == 5'd1) state_d = fxlv_pkg::ST_SECH_END;
      end
      fxlv_pkg::ST_SECH_END:  state_d = fxlv_pkg::ST_SKEW_ACC;
      fxlv_pkg::ST_SKEW_ACC:  state_d = fxlv_pkg::ST_SMILE_SUM;
      fxlv_pkg::ST_SMILE_SUM: state_d = fxlv_pkg::ST_VOL_MUL;
      fxlv_pkg::ST_VOL_MUL:   state_d = fxlv_pkg::ST_VOL_END;
      fxlv_pkg::ST_VOL_END:   state_d = fxlv_pkg::ST_DONE;
      fxlv_pkg::ST_DONE: begin
        if (load_out) state_d = fxlv_pkg::ST_IDLE;
      end
      default: state_d = fxlv_pkg::ST_IDLE;
    endcase
  end

  // control, configuration and path state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fxlv_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      init_ls_q   <= '0;
      init_vol_q  <= '0;
      lq_q        <= '0;
      cur_vol_q   <= '0;
    end else begin
      state_q <= state_d;
      if (load_out) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == fxlv_pkg::RegInitLogSpot) init_ls_q <= cfg_data_i;
        else init_vol_q <= cfg_data_i[30:0];
      end
      if (accept && s_axis_tuser == fxlv_pkg::CmdStart) begin
        lq_q      <= init_ls_q;
        cur_vol_q <= {1'b0, init_vol_q};
      end
      if (state_q == fxlv_pkg::ST_QUOT_UPD) begin
        lq_q <= lq_new;
        if (last_q) cur_vol_q <= '0;
      end
      if (state_q == fxlv_pkg::ST_VOL_END) cur_vol_q <= vol_new;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (accept) begin
      z_q    <= s_axis_tdata[31:0];
      dt_q   <= s_axis_tdata[62:32];
      sdt_q  <= s_axis_tdata[93:63];
      svol_q <= s_axis_tdata[124:94];
      a_q    <= s_axis_tdata[156:125];
      b_q    <= s_axis_tdata[188:157];
      c_q    <= s_axis_tdata[220:189];
      dom_q  <= s_axis_tdata[252:221];
      frn_q  <= s_axis_tdata[284:253];
      fwd_q  <= s_axis_tdata[316:285];
      last_q <= s_axis_tlast;
      spot_q <= init_ls_q;
      vol_q  <= {1'b0, init_vol_q};
    end
    if (load_out) begin
      out_spot_q <= spot_q;
      out_vol_q  <= vol_q;
    end
    case (state_q) inside
      // diffusion of the log quotient
      fxlv_pkg::ST_DRIFT_MUL: hold_q <= fxlv_pkg::rshr(prod_q, F);
      fxlv_pkg::ST_INNER_SAT: begin
        hold_q <= 72'(fxlv_pkg::sat32(hold_q - fxlv_pkg::rshr(prod_q, F + 1)));
      end
      fxlv_pkg::ST_QUOT_UPD: begin
        spot_q <= spot_new;
        vol_q  <= '0;
      end
      // smile deviation, cutoff and range reduction set-up
      fxlv_pkg::ST_DEV_CHK: begin
        neg_q <= w_val[71];
        f_q   <= f_cut;
        rem_q <= {4'b0, a_full[36:8]};
        low_q <= {a_full[7:0], 23'b0};
        quo_q <= '0;
        dsr_q <= 32'(fxlv_pkg::Ln2Q30);
        cnt_q <= 5'd8;
      end
      fxlv_pkg::ST_K_DIV, fxlv_pkg::ST_TANH_DIV, fxlv_pkg::ST_SECH_DIV: begin
        rem_q <= div_ge ? div_sh - {1'b0, dsr_q} : div_sh;
        low_q <= {low_q[29:0], 1'b0};
        quo_q <= {quo_q[29:0], div_ge};
        cnt_q <= cnt_q - 5'd1;
      end
      fxlv_pkg::ST_K_END: begin
        k_q    <= quo_q[7:0];
        r_q    <= rem_q[29:0];
        u_q    <= '0;
        term_q <= HypOne;
        sum_q  <= HypOne;
        n_q    <= 5'd1;
      end
      // taylor series of exp(-r)
      fxlv_pkg::ST_TAY_ACC: begin
        term_q <= tay_term;
        sum_q  <= n_q[0] ? sum_q - tay_term : sum_q + tay_term;
        n_q    <= n_q + 5'd1;
      end
      fxlv_pkg::ST_EXP_SHIFT: u_q <= sum_q >> k_q[4:0];
      // tanh numerator over 1 + u^2
      fxlv_pkg::ST_TANH_SET: begin
        dsr_q <= 32'(HypOne) + 32'(t_val);
        rem_q <= {2'b0, numer_t[61:31]};
        low_q <= numer_t[30:0];
        quo_q <= '0;
        cnt_q <= 5'd31;
      end
      fxlv_pkg::ST_TANH_END: begin
        th_q  <= quo_q;
        rem_q <= {2'b0, numer_s[61:31]};
        low_q <= numer_s[30:0];
        quo_q <= '0;
        cnt_q <= 5'd31;
      end
      // smile factor terms
      fxlv_pkg::ST_SKEW_ACC: hold_q <= fxlv_pkg::rshr(prod_q, H);
      fxlv_pkg::ST_SMILE_SUM: f_q <= f_new;
      fxlv_pkg::ST_VOL_END: vol_q <= vol_new;
      default: begin
      end
    endcase
  end

endmodule
